// ===== rtl/core/osa_pkg.sv =====
// osa_pkg: shared types, sizes and codes for the owned slot allocator
// no dependencies; used by every file in rtl/core
package osa_pkg;

    localparam int POOL_SIZE   = 16;
    localparam int SLOT_W      = 4;
    localparam int ID_W        = 7;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(POOL_SIZE);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_OWNER = 2'd3;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RANGE   = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   requester_id;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic [1:0]        status;
        logic [CNT_W-1:0]  free_slots;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   requester_id;
        logic [SLOT_W-1:0] slot_index;
    } cmd_t;

endpackage

// ===== rtl/core/osa_front.sv =====
// osa_front: accepts request beats and classifies them into commands
// depends on osa_pkg
module osa_front (
    input  logic                          req_valid,
    output logic                          req_ready,
    input  osa_pkg::req_t                 req,
    input  logic [osa_pkg::CNT_W-1:0]     limit,
    input  logic                          back_busy,
    output logic                          push_valid,
    input  logic                          push_ready,
    output osa_pkg::cmd_t                 push_cmd
);

    assign req_ready  = push_ready && !back_busy;
    assign push_valid = req_valid && !back_busy;

    always_comb
    begin
        push_cmd.requester_id = req.requester_id;
        push_cmd.slot_index   = req.slot_index;
        if (req.req_type == osa_pkg::REQ_ALLOC)
        begin
            push_cmd.op = osa_pkg::OP_ALLOC;
        end
        else if ({1'b0, req.slot_index} >= limit)
        begin
            push_cmd.op = osa_pkg::OP_RANGE;
        end
        else
        begin
            push_cmd.op = osa_pkg::OP_RELEASE;
        end
    end

endmodule

// ===== rtl/core/osa_queue.sv =====
// osa_queue: small command queue between the front and back parts
// depends on osa_pkg
module osa_queue #(
    parameter int DEPTH = osa_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  osa_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output osa_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    osa_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/osa_back.sv =====
// osa_back: slot state, owner table, limit register and response register
// depends on osa_pkg
module osa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [osa_pkg::CNT_W-1:0]     cfg_wr_data,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  osa_pkg::cmd_t                 pop_cmd,
    output logic [osa_pkg::CNT_W-1:0]     limit,
    output logic                          back_busy,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output osa_pkg::rsp_t                 rsp
);

    localparam int N  = osa_pkg::POOL_SIZE;
    localparam int SW = osa_pkg::SLOT_W;
    localparam int CW = osa_pkg::CNT_W;

    logic [N-1:0]               busy_reg, busy_next;
    logic [osa_pkg::ID_W-1:0]   owner_reg [N];
    logic [CW-1:0]              limit_reg, limit_next;
    logic [CW-1:0]              free_reg, free_next;
    logic                       sweep_reg, sweep_next;
    logic [SW-1:0]              sweep_idx_reg, sweep_idx_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    osa_pkg::rsp_t              rsp_reg, rsp_next;

    logic [N-1:0]  limit_mask;
    logic [N-1:0]  avail;
    logic          found;
    logic [SW-1:0] alloc_idx;
    logic          do_pop;
    logic          owner_wr;
    logic [CW-1:0] cfg_clamped;

    assign limit     = limit_reg;
    assign back_busy = sweep_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pop_ready = !sweep_reg && (!rsp_valid_reg || rsp_ready);
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            limit_mask[i] = (CW'(i) < limit_reg);
        end
        avail     = ~busy_reg & limit_mask;
        found     = |avail;
        alloc_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                alloc_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_clamped = CW'(1);
        end
        else if (cfg_wr_data > CW'(N))
        begin
            cfg_clamped = CW'(N);
        end
        else
        begin
            cfg_clamped = cfg_wr_data;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        limit_next     = limit_reg;
        free_next      = free_reg;
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        owner_wr       = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // recount free slots below the new limit, one slot a cycle
        if (sweep_reg)
        begin
            if (limit_mask[sweep_idx_reg] && !busy_reg[sweep_idx_reg])
            begin
                free_next = free_reg + 1'b1;
            end
            if (sweep_idx_reg == SW'(N - 1))
            begin
                sweep_next = 1'b0;
            end
            sweep_idx_next = sweep_idx_reg + 1'b1;
        end

        if (do_pop)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.granted_slot = '0;
            rsp_next.status       = osa_pkg::ST_OK;
            case (pop_cmd.op)
                osa_pkg::OP_ALLOC:
                begin
                    if (found)
                    begin
                        busy_next[alloc_idx]  = 1'b1;
                        owner_wr              = 1'b1;
                        rsp_next.granted_slot = alloc_idx;
                        if (free_reg != '0)
                        begin
                            free_next = free_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.status = osa_pkg::ST_NO_FREE;
                    end
                end
                osa_pkg::OP_RELEASE:
                begin
                    if (busy_reg[pop_cmd.slot_index]
                        && owner_reg[pop_cmd.slot_index] == pop_cmd.requester_id)
                    begin
                        busy_next[pop_cmd.slot_index] = 1'b0;
                        free_next = free_reg + 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = osa_pkg::ST_NOT_OWNER;
                    end
                end
                default:
                begin
                    rsp_next.status = osa_pkg::ST_RANGE;
                end
            endcase
            rsp_next.free_slots = free_next;
        end

        if (cfg_wr_en)
        begin
            limit_next     = cfg_clamped;
            free_next      = '0;
            sweep_next     = 1'b1;
            sweep_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            limit_reg     <= osa_pkg::LIMIT_RESET;
            free_reg      <= osa_pkg::LIMIT_RESET;
            sweep_reg     <= 1'b0;
            sweep_idx_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            limit_reg     <= limit_next;
            free_reg      <= free_next;
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (owner_wr)
        begin
            owner_reg[alloc_idx] <= pop_cmd.requester_id;
        end
    end

endmodule

// ===== rtl/core/owned_slot_allocator_top.sv =====
// a request beat is held in the command queue, then its response beat in the response register
// throughput: one request per cycle while no recount runs and responses are taken, set by the back part
// (first-free priority encode plus owner table read-modify-write)
// a configuration write starts a free-count recount over all 16 slots; requests wait
// reset: all slots free, limit 16, free count 16, queue and response empty
// depends on osa_pkg, osa_front, osa_queue, osa_back
module owned_slot_allocator_top #(
    parameter int QUEUE_DEPTH = osa_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [osa_pkg::CNT_W-1:0]     cfg_wr_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  osa_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output osa_pkg::rsp_t                 rsp
);

    logic                      push_valid, push_ready;
    osa_pkg::cmd_t             push_cmd;
    logic                      pop_valid, pop_ready;
    osa_pkg::cmd_t             pop_cmd;
    logic [osa_pkg::CNT_W-1:0] limit;
    logic                      back_busy;

    osa_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .limit      (limit),
        .back_busy  (back_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    osa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    osa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .limit       (limit),
        .back_busy   (back_busy),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

// ===== rtl/core/osa_checker.sv =====
// osa_checker: port-level checks on the allocator response channel
// depends on osa_pkg; bound to owned_slot_allocator_top
module osa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input osa_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped before acceptance");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("stalled response beat changed");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != osa_pkg::ST_OK |-> rsp.granted_slot == '0)
        else $error("failed request reports a granted slot");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.free_slots <= osa_pkg::CNT_W'(osa_pkg::POOL_SIZE))
        else $error("free count above pool size");

    a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == osa_pkg::ST_NO_FREE |-> rsp.free_slots == '0)
        else $error("no free slot reported with nonzero free count");

endmodule

bind owned_slot_allocator_top osa_checker u_osa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/tb_owned_slot_allocator_top.sv =====
// tb_owned_slot_allocator_top: self-checking bench for owned_slot_allocator_top
// directed table then random allocate/release traffic, checked against a local predictor
// depends on osa_pkg and owned_slot_allocator_top
module tb_owned_slot_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import osa_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 65;
    localparam int DIR_ROWS      = 20;

    typedef struct {
        logic             is_cfg;
        logic [CNT_W-1:0] cfg_val;
        req_t             item;
        logic             typed;
        rsp_t             want;
    } dir_row_t;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             req_valid   = 1'b0;
    logic             req_ready;
    req_t             req         = '0;
    logic             rsp_valid;
    logic             rsp_ready   = 1'b0;
    rsp_t             rsp;

    logic             slot_taken [POOL_SIZE];
    logic [ID_W-1:0]  slot_holder [POOL_SIZE];
    int               pool_limit  = POOL_SIZE;
    int               free_tally  = POOL_SIZE;
    rsp_t             pending_rsp [$];

    bit               gaps_on       = 1'b0;
    int               rsp_mode      = 0;
    bit               hold_off_req  = 1'b0;
    logic [7:0]       stall_pattern = 8'h5b;
    int               burst_left    = 0;
    int               mismatch_cnt  = 0;
    int               idle_cycles   = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd0,   4'd0},  1'b1, '{4'd0, ST_OK,        5'd15}},
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd127, 4'd15}, 1'b1, '{4'd1, ST_OK,        5'd14}},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd0,   4'd1},  1'b1, '{4'd0, ST_NOT_OWNER, 5'd14}},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd5,   4'd15}, 1'b1, '{4'd0, ST_NOT_OWNER, 5'd14}},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd127, 4'd1},  1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd42,  4'd0},  1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd85,  4'd7},  1'b0, '0},
        '{1'b1, 5'd2,  '0,                            1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd85,  4'd2},  1'b1, '{4'd0, ST_RANGE,     5'd0}},
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd9,   4'd0},  1'b1, '{4'd0, ST_NO_FREE,   5'd0}},
        '{1'b1, 5'd17, '0,                            1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd85,  4'd2},  1'b0, '0},
        '{1'b1, 5'd0,  '0,                            1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd0,   4'd0},  1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd127, 4'd0},  1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_ALLOC,   7'd1,   4'd0},  1'b1, '{4'd0, ST_NO_FREE,   5'd0}},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd1,   4'd15}, 1'b1, '{4'd0, ST_RANGE,     5'd0}},
        '{1'b1, 5'd31, '0,                            1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd42,  4'd1},  1'b0, '0},
        '{1'b0, 5'd0,  '{REQ_RELEASE, 7'd127, 4'd0},  1'b0, '0}
    };

    owned_slot_allocator_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void set_limit(logic [CNT_W-1:0] v);
        int k;
        if (v == 0)
        begin
            pool_limit = 1;
        end
        else if (int'(v) > POOL_SIZE)
        begin
            pool_limit = POOL_SIZE;
        end
        else
        begin
            pool_limit = int'(v);
        end
        free_tally = 0;
        for (k = 0; k < pool_limit; k++)
        begin
            if (!slot_taken[k])
            begin
                free_tally++;
            end
        end
    endfunction

    function automatic rsp_t serve_request(req_t r);
        rsp_t o;
        int   k;
        int   pick;
        o    = '0;
        pick = -1;
        o.status = ST_OK;
        if (r.req_type == REQ_ALLOC)
        begin
            for (k = pool_limit - 1; k >= 0; k--)
            begin
                if (!slot_taken[k])
                begin
                    pick = k;
                end
            end
            if (pick >= 0)
            begin
                slot_taken[pick]  = 1'b1;
                slot_holder[pick] = r.requester_id;
                if (free_tally > 0)
                begin
                    free_tally--;
                end
                o.granted_slot = SLOT_W'(pick);
            end
            else
            begin
                o.status = ST_NO_FREE;
            end
        end
        else if (int'(r.slot_index) >= pool_limit)
        begin
            o.status = ST_RANGE;
        end
        else if (!slot_taken[r.slot_index] || slot_holder[r.slot_index] != r.requester_id)
        begin
            o.status = ST_NOT_OWNER;
        end
        else
        begin
            slot_taken[r.slot_index]  = 1'b0;
            slot_holder[r.slot_index] = '0;
            free_tally++;
        end
        o.free_slots = CNT_W'(free_tally);
        return o;
    endfunction

    function automatic req_t make_item();
        req_t r;
        int   held [$];
        int   k;
        int   roll;
        r.requester_id = ID_W'($urandom_range(0, 127));
        r.slot_index   = SLOT_W'($urandom_range(0, 15));
        for (k = 0; k < pool_limit; k++)
        begin
            if (slot_taken[k])
            begin
                held.push_back(k);
            end
        end
        if (held.size() == 0)
        begin
            roll = 80;
        end
        else if (held.size() == pool_limit)
        begin
            roll = 20;
        end
        else
        begin
            roll = 50;
        end
        r.req_type = (int'($urandom_range(0, 99)) < roll) ? REQ_ALLOC : REQ_RELEASE;
        if (r.req_type == REQ_RELEASE && held.size() > 0)
        begin
            k    = held[$urandom_range(0, held.size() - 1)];
            roll = int'($urandom_range(0, 9));
            if (roll < 7)
            begin
                r.slot_index   = SLOT_W'(k);
                r.requester_id = slot_holder[k];
            end
            else if (roll == 7)
            begin
                r.slot_index   = SLOT_W'(k);
                r.requester_id = slot_holder[k] ^ ID_W'($urandom_range(1, 127));
            end
            else if (roll == 8 && pool_limit < POOL_SIZE)
            begin
                r.slot_index = SLOT_W'($urandom_range(pool_limit, POOL_SIZE - 1));
                if (slot_taken[r.slot_index])
                begin
                    r.requester_id = slot_holder[r.slot_index];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic send_beat(req_t r, logic typed, rsp_t want);
        rsp_t predicted;
        if (burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 12));
            if (gaps_on)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        predicted = serve_request(r);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] v);
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        set_limit(v);
    endtask

    // response side stall patterns and the long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            case (rsp_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    rsp_ready <= stall_pattern[0];
                end
            endcase
        end
    end

    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && (rsp_valid & rsp_ready) === 1'b1)
            begin
                if (pending_rsp.size() == 0)
                begin
                    report_mismatch($sformatf("response beat %h with nothing expected", rsp));
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.granted_slot !== want.granted_slot)
                    begin
                        report_mismatch($sformatf("granted_slot %0d, expected %0d",
                            rsp.granted_slot, want.granted_slot));
                    end
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                            rsp.status, want.status));
                    end
                    if (rsp.free_slots !== want.free_slots)
                    begin
                        report_mismatch($sformatf("free_slots %0d, expected %0d",
                            rsp.free_slots, want.free_slots));
                    end
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((req_valid & req_ready) === 1'b1 || (rsp_valid & rsp_ready) === 1'b1)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** owned_slot_allocator_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int               k;
        int               p;
        int               n;
        logic [CNT_W-1:0] lim;
        logic [CNT_W-1:0] lim_plan [PHASES];
        lim_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd0, 5'd0, 5'd16};
        for (k = 0; k < POOL_SIZE; k++)
        begin
            slot_taken[k]  = 1'b0;
            slot_holder[k] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gaps_on  = 1'b1;
        rsp_mode = 1;
        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_rows[k].is_cfg)
            begin
                write_limit(dir_rows[k].cfg_val);
            end
            else
            begin
                send_beat(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            gaps_on       = (p % 3 != 0);
            rsp_mode      = p % 3;
            stall_pattern = 8'($urandom_range(1, 254));
            lim = (p == 7 || p == 8) ? CNT_W'($urandom_range(0, 31)) : lim_plan[p];
            write_limit(lim);
            if (p == 4)
            begin
                gaps_on      = 1'b0;
                hold_off_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_beat(make_item(), 1'b0, '0);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
        begin
            $display("** owned_slot_allocator_top: PASSED **");
        end
        else
        begin
            $display("** owned_slot_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
